/* hw/rtl/fifo_lot_position_pnl_tracker_macros.svh */
// Assertion helpers used by the tracker back end (flpt_back).
// Both expect signals named clk and rst in the scope where they are used.
`ifndef FIFO_LOT_POSITION_PNL_TRACKER_MACROS_SVH
`define FIFO_LOT_POSITION_PNL_TRACKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLPT_CHECK_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FLPT_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/flpt_pkg.sv */
package flpt_pkg;

  localparam int PRICE_W = 31;
  localparam int VOL_W   = 20;
  localparam int CS_W    = 16;
  localparam int POS_W   = 25;
  localparam logic [23:0] POS_LIMIT = 24'hFFFFFF;

  localparam logic [1:0] MODE_FILL = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_SNAP = 2'd2;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_FILL,
    OP_TICK,
    OP_SNAP,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
  } req_t;

  typedef struct packed {
    op_t                op;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
  } q_entry_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic [PRICE_W-1:0]      average_price;
    logic signed [63:0]      realized_pnl;
    logic [62:0]             peak_pnl;
    logic signed [63:0]      max_drawdown;
    logic [62:0]             win_sum;
    logic signed [63:0]      loss_sum;
    logic [31:0]             match_count;
    logic signed [63:0]      unrealized_pnl;
    logic signed [63:0]      day_delta;
    logic                    lot_overflow;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_PUSH_ADD,
    S_READ,
    S_MATCH_MUL,
    S_MATCH_SCALE,
    S_MATCH_SUM,
    S_MATCH_PEAK,
    S_MATCH_DD,
    S_TICK_MUL,
    S_TICK_SUB,
    S_TICK_SCALE,
    S_TICK_SET,
    S_DIV_INIT,
    S_DIV,
    S_DELTA_SUM,
    S_DELTA,
    S_OUT
  } st_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? S64_MIN : S64_MAX;
    end
    return s[63:0];
  endfunction

endpackage

/* hw/rtl/fifo_lot_position_pnl_tracker.sv */
// The back end works on one item at a time, from its pop until done; a two-entry transfer
// queue takes new items meanwhile. A closing fill walks the matched lots one by one, and a
// residual opens a new lot. When the book ends flat the 31-step average price divider is
// skipped. done pulses for one cycle and the receiver cannot stall it.
module fifo_lot_position_pnl_tracker
  import flpt_pkg::*;
#(
  parameter int LOT_DEPTH = 16
)
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  req_t            request,
  output logic            busy,
  input  logic            cfg_we,
  input  logic [CS_W-1:0] cfg_data,
  output logic            done,
  output res_t            result
);

  // Reset (rst, synchronous, active high) empties the book and zeroes every total.
  // The user must write the contract multiplier only while the tracker is idle (the block
  // does not enforce it), so the back end may read it directly throughout an item.
  logic [CS_W-1:0] contract_size;
  logic            q_valid;
  logic            pop;
  q_entry_t        q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      contract_size <= CS_W'(1);
    end else if (cfg_we) begin
      contract_size <= cfg_data;
    end
  end

  // The front end classifies each transfer by mode and queues it; busy only
  // rises when the queue is full.
  flpt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  // The back end owns the lot store and all totals. A closing fill walks the
  // oldest lots one at a time; afterwards the average price is divided out
  // bit by bit and the day delta is formed before the result strobe.
  flpt_back #(
    .LOT_DEPTH (LOT_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .contract_size (contract_size),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .pop           (pop),
    .done          (done),
    .result        (result)
  );

endmodule

/* hw/rtl/flpt_front.sv */
module flpt_front
  import flpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  req_t     request,
  output logic     busy,
  input  logic     pop,
  output logic     q_valid,
  output q_entry_t q_head
);

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  q_entry_t   entry;

  // Classify the request; zero-volume fills and unused modes do nothing.
  always_comb begin
    entry.side   = request.side;
    entry.price  = request.price;
    entry.volume = request.volume;
    case (request.mode)
      MODE_FILL: entry.op = (request.volume == '0) ? OP_NOP : OP_FILL;
      MODE_TICK: entry.op = OP_TICK;
      MODE_SNAP: entry.op = OP_SNAP;
      default:   entry.op = OP_NOP;
    endcase
  end

  assign busy    = (fill == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/flpt_back.sv */
`include "fifo_lot_position_pnl_tracker_macros.svh"

module flpt_back
  import flpt_pkg::*;
#(
  parameter int LOT_DEPTH = 16
)
(
  input  logic            clk,
  input  logic            rst,
  input  logic [CS_W-1:0] contract_size,
  input  logic            q_valid,
  input  q_entry_t        q_head,
  output logic            pop,
  output logic            done,
  output res_t            result
);

  localparam int PTR_W  = $clog2(LOT_DEPTH);
  localparam int CNT_W  = $clog2(LOT_DEPTH + 1);
  localparam int HELD_W = VOL_W + PTR_W;
  localparam int COST_W = PRICE_W + HELD_W;
  localparam int PROD_W = COST_W + CS_W;
  localparam int PV_W   = PRICE_W + VOL_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LOT_DEPTH);
  localparam logic [PTR_W:0]   DEPTH_X = (PTR_W + 1)'(LOT_DEPTH);
  localparam logic [PTR_W-1:0] LAST_IX = PTR_W'(LOT_DEPTH - 1);

  logic [PRICE_W-1:0] price_mem [LOT_DEPTH];
  logic [VOL_W-1:0]   vol_mem   [LOT_DEPTH];
  logic [PRICE_W-1:0] rd_price;
  logic [VOL_W-1:0]   rd_vol;

  st_t                state, state_next;
  q_entry_t           cur;
  logic [VOL_W-1:0]   rem;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   lot_count;
  logic               held_side;
  logic [HELD_W-1:0]  held_total;
  logic [COST_W-1:0]  cost;
  logic signed [63:0] realized, peak, drawdown_low, win_total, loss_total;
  logic signed [63:0] open_pnl, snapshot, dd, sum1, delta;
  logic [31:0]        match_total;
  logic               overflow;
  logic [COST_W-1:0]  mag;
  logic [COST_W-1:0]  cost_dec;
  logic [VOL_W-1:0]   closed, lv;
  logic               neg;
  logic [PROD_W-1:0]  prod;
  logic [HELD_W-1:0]  div_rem;
  logic [PRICE_W-1:0] dvd, quot;
  logic [4:0]         div_cnt;

  logic [PTR_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail;
  logic [VOL_W-1:0]   closed_c;
  logic               up_c;
  logic [PRICE_W-1:0] diff_c;
  logic [PV_W-1:0]    pv_push, pv_diff, pv_entry;
  logic [COST_W-1:0]  tick_v;
  logic               sat_c;
  logic signed [63:0] pnl;
  logic [HELD_W:0]    trial;
  logic               ge;
  logic [23:0]        pos_mag;

  assign tail_sum = {1'b0, head} + (PTR_W + 1)'(lot_count);
  assign tail     = (tail_sum >= DEPTH_X) ? PTR_W'(tail_sum - DEPTH_X) : tail_sum[PTR_W-1:0];

  assign closed_c = (rem < rd_vol) ? rem : rd_vol;
  assign up_c     = cur.price >= rd_price;
  assign diff_c   = up_c ? cur.price - rd_price : rd_price - cur.price;
  assign pv_push  = cur.price * rem;
  assign pv_diff  = diff_c * closed_c;
  assign pv_entry = rd_price * closed_c;
  assign tick_v   = cur.price * held_total;

  // Scaled PnL saturates once the product leaves the signed 64-bit range.
  assign sat_c = |prod[PROD_W-1:63];
  always_comb begin
    if (neg) begin
      pnl = sat_c ? S64_MIN : -$signed(prod[63:0]);
    end else begin
      pnl = sat_c ? S64_MAX : $signed(prod[63:0]);
    end
  end

  assign trial = {div_rem, dvd[PRICE_W-1]};
  assign ge    = trial >= {1'b0, held_total};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:        if (q_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (cur.op)
          OP_FILL: begin
            if (lot_count == '0) begin
              state_next = S_PUSH;
            end else if (cur.side == held_side) begin
              state_next = (lot_count < CNT_MAX) ? S_PUSH : S_DIV_INIT;
            end else begin
              state_next = S_READ;
            end
          end
          OP_TICK: state_next = (held_total == '0) ? S_DIV_INIT : S_TICK_MUL;
          OP_SNAP: state_next = S_DIV_INIT;
          OP_NOP:  state_next = S_DIV_INIT;
          default: state_next = S_DIV_INIT;
        endcase
      end
      S_PUSH:        state_next = S_PUSH_ADD;
      S_PUSH_ADD:    state_next = S_DIV_INIT;
      S_READ:        state_next = S_MATCH_MUL;
      S_MATCH_MUL:   state_next = S_MATCH_SCALE;
      S_MATCH_SCALE: state_next = S_MATCH_SUM;
      S_MATCH_SUM:   state_next = S_MATCH_PEAK;
      S_MATCH_PEAK:  state_next = S_MATCH_DD;
      S_MATCH_DD: begin
        if (rem != '0 && lot_count != '0) begin
          state_next = S_READ;
        end else if (rem != '0) begin
          state_next = S_PUSH;
        end else begin
          state_next = S_DIV_INIT;
        end
      end
      S_TICK_MUL:    state_next = S_TICK_SUB;
      S_TICK_SUB:    state_next = S_TICK_SCALE;
      S_TICK_SCALE:  state_next = S_TICK_SET;
      S_TICK_SET:    state_next = S_DIV_INIT;
      S_DIV_INIT:    state_next = (held_total == '0) ? S_DELTA_SUM : S_DIV;
      S_DIV:         if (div_cnt == '0) state_next = S_DELTA_SUM;
      S_DELTA_SUM:   state_next = S_DELTA;
      S_DELTA:       state_next = S_OUT;
      S_OUT:         state_next = S_IDLE;
      default:       state_next = S_IDLE;
    endcase
  end

  // Strobes.
  always_comb begin
    pop  = 1'b0;
    done = 1'b0;
    unique case (state)
      S_IDLE:  pop  = q_valid;
      S_OUT:   done = 1'b1;
      default: ;
    endcase
  end

  // Lot store: registered read at the oldest lot.
  always_ff @(posedge clk) begin
    rd_price <= price_mem[head];
    rd_vol   <= vol_mem[head];
    if (state == S_PUSH) begin
      price_mem[tail] <= cur.price;
      vol_mem[tail]   <= rem;
    end else if (state == S_MATCH_SCALE) begin
      vol_mem[head] <= lv - closed;
    end
  end

  // Datapath without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:      if (q_valid) cur <= q_head;
      S_DECODE:    rem <= cur.volume;
      S_PUSH:      cost_dec <= COST_W'(pv_push);
      S_MATCH_MUL: begin
        mag      <= COST_W'(pv_diff);
        cost_dec <= COST_W'(pv_entry);
        closed   <= closed_c;
        lv       <= rd_vol;
        neg      <= (held_side == 1'b0) ? !up_c : up_c;
      end
      S_MATCH_SCALE: begin
        prod <= mag * contract_size;
        rem  <= rem - closed;
      end
      S_TICK_MUL:  mag <= tick_v;
      S_TICK_SUB: begin
        mag <= (mag >= cost) ? mag - cost : cost - mag;
        neg <= (held_side == 1'b0) ? (mag < cost) : (mag >= cost);
      end
      S_TICK_SCALE: prod <= mag * contract_size;
      S_DIV_INIT: begin
        div_rem <= cost[COST_W-1:PRICE_W];
        dvd     <= cost[PRICE_W-1:0];
        quot    <= '0;
        div_cnt <= 5'(PRICE_W - 1);
      end
      S_DIV: begin
        div_rem <= ge ? HELD_W'(trial - {1'b0, held_total}) : trial[HELD_W-1:0];
        dvd     <= {dvd[PRICE_W-2:0], 1'b0};
        quot    <= {quot[PRICE_W-2:0], ge};
        div_cnt <= div_cnt - 5'd1;
      end
      S_DELTA_SUM: sum1  <= sat_add(realized, open_pnl);
      S_DELTA:     delta <= sat_sub(sum1, snapshot);
      default: ;
    endcase
  end

  // Position and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      lot_count    <= '0;
      held_side    <= 1'b0;
      held_total   <= '0;
      cost         <= '0;
      realized     <= '0;
      peak         <= '0;
      drawdown_low <= '0;
      win_total    <= '0;
      loss_total   <= '0;
      match_total  <= '0;
      open_pnl     <= '0;
      snapshot     <= '0;
      overflow     <= 1'b0;
      dd           <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_DECODE: begin
          overflow <= 1'b0;
          unique case (cur.op)
            OP_FILL: begin
              open_pnl <= '0;
              if (lot_count == CNT_MAX && cur.side == held_side) begin
                overflow <= 1'b1;
              end
            end
            OP_TICK: if (held_total == '0) open_pnl <= '0;
            OP_SNAP: snapshot <= realized;
            OP_NOP:  ;
            default: ;
          endcase
        end
        S_PUSH: begin
          held_side  <= cur.side;
          lot_count  <= lot_count + CNT_W'(1);
          held_total <= held_total + HELD_W'(rem);
        end
        S_PUSH_ADD: cost <= cost + cost_dec;
        S_MATCH_SCALE: begin
          cost       <= cost - cost_dec;
          held_total <= held_total - HELD_W'(closed);
          if (lv == closed) begin
            lot_count <= lot_count - CNT_W'(1);
            head      <= (head == LAST_IX) ? '0 : head + PTR_W'(1);
          end
        end
        S_MATCH_SUM: begin
          realized <= sat_add(realized, pnl);
          if (match_total != 32'hFFFF_FFFF) match_total <= match_total + 32'd1;
          if (pnl >= 0) begin
            win_total <= sat_add(win_total, pnl);
          end else begin
            loss_total <= sat_add(loss_total, pnl);
          end
        end
        S_MATCH_PEAK: begin
          if (realized > peak) begin
            peak <= realized;
            dd   <= '0;
          end else begin
            dd <= sat_sub(realized, peak);
          end
        end
        S_MATCH_DD:  if (dd < drawdown_low) drawdown_low <= dd;
        S_TICK_SET:  open_pnl <= pnl;
        default: ;
      endcase
    end
  end

  assign pos_mag = (64'(held_total) > 64'(POS_LIMIT)) ? POS_LIMIT : 24'(held_total);

  always_comb begin
    result.position       = held_side ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});
    result.average_price  = (held_total == '0) ? '0 : quot;
    result.realized_pnl   = realized;
    result.peak_pnl       = peak[62:0];
    result.max_drawdown   = drawdown_low;
    result.win_sum        = win_total[62:0];
    result.loss_sum       = loss_total;
    result.match_count    = match_total;
    result.unrealized_pnl = open_pnl;
    result.day_delta      = delta;
    result.lot_overflow   = overflow;
  end

  `FLPT_CHECK_NOW(a_count_bound, 1'b1, lot_count <= CNT_MAX, "lot count above depth")
  `FLPT_CHECK_NOW(a_flat_book, lot_count == '0, held_total == '0, "volume held with no lots")
  `FLPT_CHECK_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule
